>>> sv/line_table_row_encoder_assert.svh
// assertion macros for the line table row encoder
// no dependencies; taken in by every module that carries assertions
`ifndef LINE_TABLE_ROW_ENCODER_ASSERT_SVH
`define LINE_TABLE_ROW_ENCODER_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define LTRE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ltre assertion failed");
// condition must never be seen out of reset
`define LTRE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("ltre forbidden condition seen");
`else
`define LTRE_ASSERT(lbl, clk, rstn, prop)
`define LTRE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> sv/ltre_pkg.sv
// shared types, opcodes and constants of the line table row encoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ltre_pkg;

  // standard opcodes of the line-number program
  localparam logic [7:0] OP_COPY       = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LN = 8'd3;
  localparam logic [7:0] OP_SET_FILE   = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN = 8'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_RANGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPCODE_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INST_LEN = 3'd3;

  // register reset values
  localparam logic [7:0] RST_LINE_BASE    = 8'd0;
  localparam logic [7:0] RST_LINE_RANGE   = 8'd0;
  localparam logic [7:0] RST_OPCODE_BASE  = 8'd13;
  localparam logic [7:0] RST_MIN_INST_LEN = 8'd1;
  localparam logic [15:0] RST_FILE   = 16'd1;
  localparam logic [15:0] RST_COLUMN = 16'd0;

  // divider: quotient bits per cycle and cycle count
  localparam int DIVIDEND_W  = 16;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_CYCLES  = DIVIDEND_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
  localparam int PROD_W      = 24;
  localparam int OPC_W       = 26;

  // command queue depth
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // byte sequence phases, one bit each in the pending vector
  localparam int NPHASE = 10;
  typedef enum logic [3:0] {
    PH_FILE_OP  = 4'd0,
    PH_FILE_VAL = 4'd1,
    PH_COL_OP   = 4'd2,
    PH_COL_VAL  = 4'd3,
    PH_SPECIAL  = 4'd4,
    PH_LINE_OP  = 4'd5,
    PH_LINE_VAL = 4'd6,
    PH_PC_OP    = 4'd7,
    PH_PC_VAL   = 4'd8,
    PH_COPY     = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_MUL,
    FR_PUSH
  } front_state_e;

  typedef struct packed {
    logic signed [7:0] line_base;
    logic [7:0]        line_range;
    logic [7:0]        opcode_base;
    logic [7:0]        min_inst_length;
  } cfg_t;

  // one classified row, handed from front to back
  typedef struct packed {
    logic              set_file;
    logic [15:0]       file;
    logic              set_col;
    logic [15:0]       col;
    logic              special;
    logic [7:0]        spec_byte;
    logic              line_nz;
    logic signed [15:0] dline;
    logic              pc_nz;
    logic [15:0]       adv;
  } cmd_t;

endpackage

>>> sv/ltre_front.sv
// front end: accepts rows, divides the address delta, classifies the row
// depends on ltre_pkg and line_table_row_encoder_assert.svh
`timescale 1ns / 1ps
`include "line_table_row_encoder_assert.svh"

module ltre_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ltre_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         file_index_i,
  input  logic [15:0]         column_i,
  input  logic signed [15:0]  delta_line_i,
  input  logic [15:0]         delta_pc_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output ltre_pkg::cmd_t      push_cmd_o
);

  ltre_pkg::front_state_e state_q, state_d;
  logic [15:0]        file_q, col_q;
  logic signed [15:0] dl_q;
  logic [ltre_pkg::DIVIDEND_W-1:0] acc_q, acc_d;
  logic [7:0]         rem_q, rem_d;
  logic [ltre_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [ltre_pkg::PROD_W-1:0] prod_q;
  logic [15:0]        cur_file_q, cur_col_q;
  logic [7:0]         divisor;
  logic               accept, push_done;
  logic signed [17:0] rel;
  logic [ltre_pkg::OPC_W-1:0] opc;
  logic               fits;

  function automatic logic signed [17:0] delta_ext(input logic signed [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

  // zero instruction length acts as one
  assign divisor = (cfg_i.min_inst_length == 8'd0) ? 8'd1 : cfg_i.min_inst_length;

  assign accept    = in_valid_i && !in_stall_o;
  assign push_done = push_valid_o && push_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ltre_pkg::FR_IDLE: if (in_valid_i) state_d = ltre_pkg::FR_DIV;
      ltre_pkg::FR_DIV: begin
        if (cnt_q == ltre_pkg::DIV_CNT_W'(ltre_pkg::DIV_CYCLES - 1)) begin
          state_d = ltre_pkg::FR_MUL;
        end
      end
      ltre_pkg::FR_MUL:  state_d = ltre_pkg::FR_PUSH;
      ltre_pkg::FR_PUSH: if (push_ready_i) state_d = ltre_pkg::FR_IDLE;
      default:           state_d = ltre_pkg::FR_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o   = 1'b1;
    push_valid_o = 1'b0;
    case (state_q)
      ltre_pkg::FR_IDLE: in_stall_o = 1'b0;
      ltre_pkg::FR_PUSH: push_valid_o = 1'b1;
      default: begin
        in_stall_o   = 1'b1;
        push_valid_o = 1'b0;
      end
    endcase
  end

  // restoring divider, two quotient bits per cycle
  always_comb begin
    logic [8:0] r9;
    acc_d = acc_q;
    rem_d = rem_q;
    for (int s = 0; s < ltre_pkg::DIV_STEPS; s++) begin
      r9    = {rem_d, acc_d[ltre_pkg::DIVIDEND_W-1]};
      acc_d = {acc_d[ltre_pkg::DIVIDEND_W-2:0], 1'b0};
      if (r9 >= {1'b0, divisor}) begin
        rem_d    = 8'(r9 - {1'b0, divisor});
        acc_d[0] = 1'b1;
      end else begin
        rem_d = r9[7:0];
      end
    end
  end

  // special opcode test: rel in range and opcode not above 255
  assign rel  = 18'(delta_ext(dl_q)) - 18'(cfg_i.line_base);
  assign opc  = ltre_pkg::OPC_W'(rel[8:0]) + ltre_pkg::OPC_W'(prod_q)
              + ltre_pkg::OPC_W'(cfg_i.opcode_base);
  assign fits = !rel[17] && (rel < $signed({10'd0, cfg_i.line_range}))
              && (opc <= ltre_pkg::OPC_W'(255));

  // command assembly
  always_comb begin
    push_cmd_o.set_file  = (file_q != cur_file_q);
    push_cmd_o.file      = file_q;
    push_cmd_o.set_col   = (col_q != cur_col_q);
    push_cmd_o.col       = col_q;
    push_cmd_o.special   = fits;
    push_cmd_o.spec_byte = opc[7:0];
    push_cmd_o.line_nz   = (dl_q != 16'sd0);
    push_cmd_o.dline     = dl_q;
    push_cmd_o.pc_nz     = (acc_q != '0);
    push_cmd_o.adv       = acc_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ltre_pkg::FR_IDLE;
      cnt_q      <= '0;
      cur_file_q <= ltre_pkg::RST_FILE;
      cur_col_q  <= ltre_pkg::RST_COLUMN;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == ltre_pkg::FR_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (push_done) begin
        cur_file_q <= file_q;
        cur_col_q  <= col_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      file_q <= file_index_i;
      col_q  <= column_i;
      dl_q   <= delta_line_i;
      acc_q  <= delta_pc_i;
      rem_q  <= '0;
    end else if (state_q == ltre_pkg::FR_DIV) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
    if (state_q == ltre_pkg::FR_MUL) begin
      prod_q <= ltre_pkg::PROD_W'(cfg_i.line_range * acc_q);
    end
  end

  `LTRE_ASSERT(a_rem_below_div, clk_i, rst_ni,
    (state_q == ltre_pkg::FR_DIV) |-> ({1'b0, rem_q} < {1'b0, divisor}))
  `LTRE_ASSERT(a_div_to_mul, clk_i, rst_ni,
    (state_q == ltre_pkg::FR_DIV && cnt_q == ltre_pkg::DIV_CNT_W'(ltre_pkg::DIV_CYCLES - 1))
      |=> (state_q == ltre_pkg::FR_MUL))
  `LTRE_ASSERT(a_cur_file_update, clk_i, rst_ni,
    push_done |=> (cur_file_q == $past(file_q) && cur_col_q == $past(col_q)))

endmodule

>>> sv/ltre_queue.sv
// short command queue between front and back
// depends on ltre_pkg
`timescale 1ns / 1ps

module ltre_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ltre_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ltre_pkg::cmd_t pop_cmd_o
);

  ltre_pkg::cmd_t entry_q [ltre_pkg::QDEPTH];
  logic [ltre_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ltre_pkg::QCNT_W-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != ltre_pkg::QCNT_W'(ltre_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

>>> sv/ltre_back.sv
// back end: walks a classified row and sends its program bytes
// depends on ltre_pkg and line_table_row_encoder_assert.svh
`timescale 1ns / 1ps
`include "line_table_row_encoder_assert.svh"

module ltre_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  ltre_pkg::cmd_t pop_cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           last_byte_o
);

  logic [ltre_pkg::NPHASE-1:0] pend_q, pend_d, en;
  ltre_pkg::cmd_t     cmd_q;
  logic [16:0]        val_q, val_d;
  logic               out_valid_q;
  logic [7:0]         out_byte_q, byte_d;
  logic               last_q, last_d;
  logic               emit, seg_done, load;
  ltre_pkg::phase_e   phase;
  logic [16:0]        rest_u, rest_s;
  logic               done_u, done_s;

  function automatic logic [3:0] low_idx(input logic [ltre_pkg::NPHASE-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = ltre_pkg::NPHASE - 1; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  assign load        = (pend_q == '0) && pop_valid_i;
  assign pop_ready_o = (pend_q == '0);
  assign emit        = (pend_q != '0) && (!out_valid_q || !out_stall_i);
  assign phase       = ltre_pkg::phase_e'(low_idx(pend_q));

  // phases that a fresh row enables
  always_comb begin
    en = '0;
    en[ltre_pkg::PH_FILE_OP]  = pop_cmd_i.set_file;
    en[ltre_pkg::PH_FILE_VAL] = pop_cmd_i.set_file;
    en[ltre_pkg::PH_COL_OP]   = pop_cmd_i.set_col;
    en[ltre_pkg::PH_COL_VAL]  = pop_cmd_i.set_col;
    en[ltre_pkg::PH_SPECIAL]  = pop_cmd_i.special;
    en[ltre_pkg::PH_LINE_OP]  = !pop_cmd_i.special && pop_cmd_i.line_nz;
    en[ltre_pkg::PH_LINE_VAL] = !pop_cmd_i.special && pop_cmd_i.line_nz;
    en[ltre_pkg::PH_PC_OP]    = !pop_cmd_i.special && pop_cmd_i.pc_nz;
    en[ltre_pkg::PH_PC_VAL]   = !pop_cmd_i.special && pop_cmd_i.pc_nz;
    en[ltre_pkg::PH_COPY]     = !pop_cmd_i.special;
  end

  // leb128 groups: unsigned and signed continuation tests
  assign rest_u = val_q >> 7;
  assign rest_s = 17'($signed(val_q) >>> 7);
  assign done_u = (rest_u == '0);
  assign done_s = ((rest_s == '0) && !val_q[6]) || ((rest_s == '1) && val_q[6]);

  // byte of the current phase
  always_comb begin
    byte_d   = ltre_pkg::OP_COPY;
    val_d    = val_q;
    seg_done = 1'b1;
    case (phase)
      ltre_pkg::PH_FILE_OP: begin
        byte_d = ltre_pkg::OP_SET_FILE;
        val_d  = {1'b0, cmd_q.file};
      end
      ltre_pkg::PH_COL_OP: begin
        byte_d = ltre_pkg::OP_SET_COLUMN;
        val_d  = {1'b0, cmd_q.col};
      end
      ltre_pkg::PH_LINE_OP: begin
        byte_d = ltre_pkg::OP_ADVANCE_LN;
        val_d  = {cmd_q.dline[15], cmd_q.dline};
      end
      ltre_pkg::PH_PC_OP: begin
        byte_d = ltre_pkg::OP_ADVANCE_PC;
        val_d  = {1'b0, cmd_q.adv};
      end
      ltre_pkg::PH_FILE_VAL, ltre_pkg::PH_COL_VAL, ltre_pkg::PH_PC_VAL: begin
        byte_d   = {!done_u, val_q[6:0]};
        val_d    = rest_u;
        seg_done = done_u;
      end
      ltre_pkg::PH_LINE_VAL: begin
        byte_d   = {!done_s, val_q[6:0]};
        val_d    = rest_s;
        seg_done = done_s;
      end
      ltre_pkg::PH_SPECIAL: byte_d = cmd_q.spec_byte;
      ltre_pkg::PH_COPY:    byte_d = ltre_pkg::OP_COPY;
      default:              byte_d = ltre_pkg::OP_COPY;
    endcase
  end

  // retire a finished phase; last byte when nothing else is pending
  always_comb begin
    pend_d = pend_q;
    if (seg_done) pend_d[phase] = 1'b0;
    last_d = seg_done && (pend_d == '0);
  end

  // sequencer control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        pend_q <= en;
      end else if (emit) begin
        pend_q <= pend_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // row, operand and output byte registers
  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= pop_cmd_i;
    if (emit) begin
      val_q      <= val_d;
      out_byte_q <= byte_d;
      last_q     <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_q;

  `LTRE_ASSERT(a_row_has_end, clk_i, rst_ni,
    (pend_q != '0) |-> (pend_q[ltre_pkg::PH_SPECIAL] || pend_q[ltre_pkg::PH_COPY]))
  `LTRE_ASSERT_NEVER(a_special_and_copy, clk_i, rst_ni,
    pend_q[ltre_pkg::PH_SPECIAL] && pend_q[ltre_pkg::PH_COPY])
  `LTRE_ASSERT(a_last_ends_row, clk_i, rst_ni,
    (emit && last_d) |=> (pend_q == '0 && last_byte_o))

endmodule

>>> sv/line_table_row_encoder.sv
// line table row encoder: one row in, its line-number program bytes out
// path: the front's divider and multiplier, the queue, then the byte sequencer
// flow: the front takes a new row only once the last is pushed, bound by the
//   radix-4 address delta divider; back sends a byte per cycle unless stalled
// reset: asynchronous, active low; registers to defaults, file 1, column 0
// depends on ltre_pkg, ltre_front, ltre_queue, ltre_back
`timescale 1ns / 1ps

module line_table_row_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         file_index_i,
  input  logic [15:0]         column_i,
  input  logic signed [15:0]  delta_line_i,
  input  logic [15:0]         delta_pc_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o
);

  ltre_pkg::cfg_t cfg_q;
  ltre_pkg::cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_base       <= ltre_pkg::RST_LINE_BASE;
      cfg_q.line_range      <= ltre_pkg::RST_LINE_RANGE;
      cfg_q.opcode_base     <= ltre_pkg::RST_OPCODE_BASE;
      cfg_q.min_inst_length <= ltre_pkg::RST_MIN_INST_LEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ltre_pkg::REG_LINE_BASE:    cfg_q.line_base       <= cfg_data_i;
        ltre_pkg::REG_LINE_RANGE:   cfg_q.line_range      <= cfg_data_i;
        ltre_pkg::REG_OPCODE_BASE:  cfg_q.opcode_base     <= cfg_data_i;
        ltre_pkg::REG_MIN_INST_LEN: cfg_q.min_inst_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // row intake and classification
  ltre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .file_index_i (file_index_i),
    .column_i     (column_i),
    .delta_line_i (delta_line_i),
    .delta_pc_i   (delta_pc_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // decoupling queue
  ltre_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // byte sequencer
  ltre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

>>> tb/line_table_row_encoder_test.sv
`timescale 1ns / 1ps
// self-checking bench for line_table_row_encoder: rows are encoded by a local model
// and every program byte is compared on transfer; depends on ltre_pkg and the block

module line_table_row_encoder_test;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 32;
  localparam int IDLE_LIMIT     = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int ROWS_PER_PHASE = 33;
  localparam int MAX_REPORTS    = 50;
  localparam logic [ltre_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd4;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_ALTERNATE,
    STALL_BURSTY
  } stall_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } prog_byte_t;

  // block ports
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [ltre_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [7:0]           cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [15:0]          file_index_i = '0;
  logic [15:0]          column_i     = '0;
  logic signed [15:0]   delta_line_i = '0;
  logic [15:0]          delta_pc_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [7:0]           out_byte_o;
  logic                 last_byte_o;

  // encoder model state and configuration
  logic signed [7:0] enc_line_base    = ltre_pkg::RST_LINE_BASE;
  logic [7:0]        enc_line_range   = ltre_pkg::RST_LINE_RANGE;
  logic [7:0]        enc_opcode_base  = ltre_pkg::RST_OPCODE_BASE;
  logic [7:0]        enc_min_inst_len = ltre_pkg::RST_MIN_INST_LEN;
  logic [15:0]       enc_file         = ltre_pkg::RST_FILE;
  logic [15:0]       enc_column       = ltre_pkg::RST_COLUMN;

  prog_byte_t  expected_bytes[$];
  logic [7:0]  row_bytes[$];

  int error_count     = 0;
  int rows_sent       = 0;
  int bytes_checked   = 0;
  int special_count   = 0;
  int settings_loaded = 0;
  int idle_cycles     = 0;

  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  stall_tick = '0;

  line_table_row_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .file_index_i (file_index_i),
    .column_i     (column_i),
    .delta_line_i (delta_line_i),
    .delta_pc_i   (delta_pc_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

  // clock
  initial begin
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  // one line per mismatch, printing capped
  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  // unsigned leb128 operand into the current row
  function automatic void append_uleb(int unsigned v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      row_bytes.push_back(b);
    end while (v != 0);
  endfunction

  // predicted program bytes of one row, queued in order
  function automatic void encode_row(logic [15:0] file, logic [15:0] col,
                                     logic signed [15:0] dline, logic [15:0] dpc);
    int unsigned divisor;
    int unsigned advance;
    longint      rel;
    longint      opc;
    int          sl;
    logic [7:0]  b;
    bit          more;
    divisor = (enc_min_inst_len == 8'd0) ? 1 : enc_min_inst_len;
    advance = dpc / divisor;
    rel = longint'(dline) - longint'(enc_line_base);
    opc = rel + longint'(enc_line_range) * longint'(advance) + longint'(enc_opcode_base);
    row_bytes.delete();
    if (file != enc_file) begin
      row_bytes.push_back(ltre_pkg::OP_SET_FILE);
      append_uleb(32'(file));
      enc_file = file;
    end
    if (col != enc_column) begin
      row_bytes.push_back(ltre_pkg::OP_SET_COLUMN);
      append_uleb(32'(col));
      enc_column = col;
    end
    if (rel >= 0 && rel < longint'(enc_line_range) && opc >= 0 && opc <= 255) begin
      row_bytes.push_back(8'(opc));
      special_count++;
    end else begin
      // long form: signed line advance, operation advance, copy
      if (dline != 0) begin
        row_bytes.push_back(ltre_pkg::OP_ADVANCE_LN);
        sl = int'(dline);
        more = 1'b1;
        while (more) begin
          b = {1'b0, sl[6:0]};
          sl = sl >>> 7;
          if ((sl == 0 && !b[6]) || (sl == -1 && b[6])) more = 1'b0;
          else b[7] = 1'b1;
          row_bytes.push_back(b);
        end
      end
      if (advance != 0) begin
        row_bytes.push_back(ltre_pkg::OP_ADVANCE_PC);
        append_uleb(advance);
      end
      row_bytes.push_back(ltre_pkg::OP_COPY);
    end
    foreach (row_bytes[k]) begin
      expected_bytes.push_back('{data: row_bytes[k], is_last: (k == row_bytes.size() - 1)});
    end
  endfunction

  // one row transfer; valid stays high for a following row
  task automatic send_row(logic [15:0] file, logic [15:0] col,
                          logic signed [15:0] dline, logic [15:0] dpc);
    in_valid_i   <= 1'b1;
    file_index_i <= file;
    column_i     <= col;
    delta_line_i <= dline;
    delta_pc_i   <= dpc;
    do @(posedge clk_i); while (in_stall_o);
    encode_row(file, col, dline, dpc);
    rows_sent++;
  endtask

  // sender gap
  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // hold off until every predicted byte has come out, then let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // single register write; enable is left high for back-to-back writes
  task automatic write_reg(logic [ltre_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      ltre_pkg::REG_LINE_BASE:    enc_line_base    = data;
      ltre_pkg::REG_LINE_RANGE:   enc_line_range   = data;
      ltre_pkg::REG_OPCODE_BASE:  enc_opcode_base  = data;
      ltre_pkg::REG_MIN_INST_LEN: enc_min_inst_len = data;
      default: ;
    endcase
  endtask

  // full register set, written only once the block is idle
  task automatic load_settings(logic [7:0] lbase, logic [7:0] lrange,
                               logic [7:0] obase, logic [7:0] mil);
    wait_drained();
    write_reg(ltre_pkg::REG_LINE_BASE, lbase);
    write_reg(ltre_pkg::REG_LINE_RANGE, lrange);
    write_reg(ltre_pkg::REG_OPCODE_BASE, obase);
    write_reg(ltre_pkg::REG_MIN_INST_LEN, mil);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_loaded++;
  endtask

  // reset settings: zero line range forces the long form everywhere
  task automatic test_default_settings();
    send_row(16'd1, 16'd0, 16'sd0, 16'd0);
    send_row(16'd1, 16'd0, 16'sd1, 16'd1);
    send_row(16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'hFFFF);
    send_row(16'd0, 16'd0, -16'sd32768, 16'd0);
    send_row(16'd0, 16'd0, -16'sd1, 16'd127);
    send_row(16'd2, 16'd127, 16'sd63, 16'd128);
    send_row(16'd128, 16'd128, 16'sd64, 16'd16383);
    send_row(16'd128, 16'd128, -16'sd64, 16'd16384);
    send_row(16'd3, 16'd1, -16'sd65, 16'd0);
  endtask

  // special opcode window edges, advance truncation and opcode overflow
  task automatic test_special_opcodes();
    load_settings(8'(-5), 8'd14, 8'd13, 8'd4);
    send_row(16'd3, 16'd1, -16'sd5, 16'd0);
    send_row(16'd3, 16'd1, 16'sd8, 16'd4);
    send_row(16'd3, 16'd1, 16'sd9, 16'd0);
    send_row(16'd3, 16'd1, -16'sd6, 16'd0);
    send_row(16'd3, 16'd1, 16'sd0, 16'd3);
    send_row(16'd3, 16'd1, 16'sd0, 16'd100);
    send_row(16'd5, 16'd9, 16'sd2, 16'd8);
  endtask

  // register extremes, zero instruction length and unused register indexes
  task automatic test_register_extremes();
    load_settings(8'h80, 8'd255, 8'd255, 8'd255);
    send_row(16'd3, 16'd1, -16'sd128, 16'd0);
    send_row(16'd3, 16'd1, -16'sd127, 16'd0);
    load_settings(8'h7F, 8'd1, 8'd0, 8'd0);
    send_row(16'd3, 16'd1, 16'sd127, 16'd0);
    send_row(16'd3, 16'd1, 16'sd127, 16'd5);
    send_row(16'd3, 16'd1, 16'sd126, 16'd0);
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      write_reg(3'(REG_FIRST_UNUSED + i), 8'($urandom));
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_row(16'd3, 16'd1, 16'sd127, 16'd2);
  endtask

  // random settings per phase; rows mostly aimed at the special opcode window
  task automatic test_random_rows();
    logic [7:0]         lbase;
    logic [7:0]         lrange;
    logic [7:0]         obase;
    logic [7:0]         mil;
    logic [15:0]        file;
    logic [15:0]        col;
    logic signed [15:0] dline;
    logic [15:0]        dpc;
    int                 sent;
    int                 burst;
    int                 span;
    int                 unit;
    int                 kind;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: begin
          lbase  = 8'($urandom);
          lrange = 8'($urandom);
          obase  = 8'($urandom);
          mil    = 8'($urandom);
        end
        1: begin
          lbase  = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
          lrange = $urandom_range(0, 1) ? 8'd0 : 8'd255;
          obase  = $urandom_range(0, 1) ? 8'd0 : 8'd255;
          case ($urandom_range(0, 2))
            0:       mil = 8'd0;
            1:       mil = 8'd1;
            default: mil = 8'd255;
          endcase
        end
        default: begin
          lbase  = 8'(-int'($urandom_range(1, 10)));
          lrange = 8'($urandom_range(4, 16));
          obase  = 8'($urandom_range(10, 14));
          mil    = 8'($urandom_range(1, 4));
        end
      endcase
      load_settings(lbase, lrange, obase, mil);
      sent = 0;
      while (sent < ROWS_PER_PHASE) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst && sent < ROWS_PER_PHASE; j++) begin
          kind = $urandom_range(0, 9);
          span = (enc_line_range == 8'd0) ? 1 : enc_line_range;
          unit = (enc_min_inst_len == 8'd0) ? 1 : enc_min_inst_len;
          // file mostly repeats and column repeats in under half the rows, as in a real line table
          if (kind >= 8) file = 16'($urandom);
          else if ($urandom_range(0, 4) == 0) file = 16'($urandom_range(1, 6));
          else file = enc_file;
          if (kind >= 8) col = 16'($urandom);
          else if ($urandom_range(0, 1) == 0) col = 16'($urandom_range(0, 200));
          else col = enc_column;
          if (kind <= 5) begin
            dline = 16'(int'(enc_line_base) + int'($urandom_range(0, span - 1)));
            dpc   = 16'($urandom_range(0, 6 * unit));
          end else if (kind <= 7) begin
            dline = 16'(int'($urandom_range(0, 4000)) - 2000);
            dpc   = 16'($urandom_range(0, 3000));
          end else begin
            dline = 16'($urandom);
            dpc   = 16'($urandom);
          end
          send_row(file, col, dline, dpc);
          sent++;
        end
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
    end
  endtask

  // receiver stall pattern, mode drawn anew whenever the low six tick bits are zero
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:      out_stall_i <= 1'b0;
      STALL_RANDOM:    out_stall_i <= ($urandom_range(0, 2) == 0);
      STALL_ALTERNATE: out_stall_i <= ~out_stall_i;
      default:         out_stall_i <= (stall_tick[3:0] < 4'd10);
    endcase
  end

  // byte checker against the oldest prediction
  always @(posedge clk_i) begin
    prog_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing predicted", out_byte_o));
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte_o !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, predicted %02h", out_byte_o, want.data));
        end
        if (last_byte_o !== want.is_last) begin
          report_mismatch($sformatf("last_byte %b, predicted %b (byte %02h)",
                                    last_byte_o, want.is_last, want.data));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes still predicted",
               IDLE_LIMIT, expected_bytes.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_settings();
    test_special_opcodes();
    test_register_extremes();
    test_random_rows();
    wait_drained();
    $display("covered %0d rows under %0d register settings plus reset defaults",
             rows_sent, settings_loaded);
    $display("checked %0d program bytes, %0d of them special opcodes, %0d mismatches",
             bytes_checked, special_count, error_count);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
